// ===== rtl/button_press_duration_classifier_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the button press classifier RTL.
// Each macro expects the module to have ports named clock and reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_DURATION_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_DURATION_CLASSIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPDC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPDC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bpdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpdc_pkg
// Types and constants of the button press duration classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bpdc_pkg;

   // Field and port widths.
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int TDATA_W     = 8;
   localparam int EVENT_W     = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_SETTLE_SAMPLES    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLES_PER_UNIT  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SHORT_LIMIT_UNITS = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TIMEOUT_UNITS     = 8'd3;

   // Register reset values.
   localparam logic [7:0]  RST_SETTLE_SAMPLES    = 8'd5;
   localparam logic [15:0] RST_SAMPLES_PER_UNIT  = 16'd500;
   localparam logic [7:0]  RST_SHORT_LIMIT_UNITS = 8'd5;
   localparam logic [7:0]  RST_TIMEOUT_UNITS     = 8'd50;

   // Press event codes.
   localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
   localparam logic [EVENT_W-1:0] EV_SHORT = 2'd1;
   localparam logic [EVENT_W-1:0] EV_LONG  = 2'd2;

   // Detector phase.
   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_SETTLE = 2'd1,
      PH_HOLD   = 2'd2
   } phase_type;

   // Configuration register set as seen by the detector.
   typedef struct packed {
      logic [7:0]  settle_samples;
      logic [15:0] samples_per_unit;
      logic [7:0]  short_limit_units;
      logic [7:0]  timeout_units;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/bpdc_csr.sv =====
// ----------------------------------------------------------------------------
// bpdc_csr
// Configuration registers, written through an indexed valid/ready port.
// ----------------------------------------------------------------------------
`default_nettype none

module bpdc_csr
   import bpdc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output      cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Decode the index; unknown indexes leave the registers untouched.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_SETTLE_SAMPLES:    cfg_in.settle_samples    = csr_data[7:0];
            REG_SAMPLES_PER_UNIT:  cfg_in.samples_per_unit  = csr_data;
            REG_SHORT_LIMIT_UNITS: cfg_in.short_limit_units = csr_data[7:0];
            REG_TIMEOUT_UNITS:     cfg_in.timeout_units     = csr_data[7:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_samples    <= RST_SETTLE_SAMPLES;
         cfg_ff.samples_per_unit  <= RST_SAMPLES_PER_UNIT;
         cfg_ff.short_limit_units <= RST_SHORT_LIMIT_UNITS;
         cfg_ff.timeout_units     <= RST_TIMEOUT_UNITS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/bpdc_core.sv =====
// ----------------------------------------------------------------------------
// bpdc_core
// Edge, settle and hold-unit state machine; one sample per step.
// ----------------------------------------------------------------------------
`default_nettype none

module bpdc_core
   import bpdc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic               level,
   input  wire cfg_type            cfg,
   output      logic [EVENT_W-1:0] press_event
);

`include "button_press_duration_classifier_assert.svh"

   phase_type   phase_ff, phase_in;
   logic        prev_ff, prev_in;
   logic [7:0]  settle_ff, settle_in;
   logic [15:0] usc_ff, usc_in;
   logic [7:0]  held_ff, held_in;

   logic [7:0]  settle_inc;
   logic [15:0] usc_inc;
   logic [7:0]  held_inc;
   logic        settle_done;
   logic        unit_done;
   logic        hold_stop;
   logic        timed_out;
   logic        edge_seen;

   // Saturating counters and the compares that drive the phase changes.
   always_comb begin
      settle_inc  = (!level) ? ((settle_ff == 8'hFF) ? settle_ff : settle_ff + 8'd1) : 8'd0;
      usc_inc     = (usc_ff == 16'hFFFF) ? usc_ff : usc_ff + 16'd1;
      held_inc    = (held_ff == 8'hFF) ? held_ff : held_ff + 8'd1;
      settle_done = (settle_inc >= cfg.settle_samples);
      unit_done   = (usc_inc >= cfg.samples_per_unit);
      hold_stop   = (cfg.timeout_units <= 8'd1);
      timed_out   = (held_inc >= cfg.timeout_units);
      edge_seen   = !level && prev_ff;
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_SETTLE: begin
            if (settle_done) begin
               phase_in = hold_stop ? PH_IDLE : PH_HOLD;
            end
         end
         PH_HOLD: begin
            if (unit_done && (level || timed_out)) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (edge_seen) begin
               if (cfg.settle_samples == 8'd0) begin
                  phase_in = hold_stop ? PH_IDLE : PH_HOLD;
               end else begin
                  phase_in = PH_SETTLE;
               end
            end
         end
      endcase
   end

   // Counters, tracked level and the press event.
   always_comb begin
      prev_in     = prev_ff;
      settle_in   = settle_ff;
      usc_in      = usc_ff;
      held_in     = held_ff;
      press_event = EV_NONE;
      unique case (phase_ff)
         PH_SETTLE: begin
            settle_in = settle_inc;
            if (settle_done) begin
               held_in = 8'd1;
               usc_in  = 16'd0;
               if (hold_stop) begin
                  prev_in = 1'b0;
               end
            end
         end
         PH_HOLD: begin
            usc_in = usc_inc;
            if (unit_done) begin
               usc_in = 16'd0;
               if (!level) begin
                  held_in = held_inc;
                  if (timed_out) begin
                     prev_in = 1'b0;
                  end
               end else begin
                  press_event = (held_ff < cfg.short_limit_units) ? EV_SHORT : EV_LONG;
                  prev_in     = 1'b1;
               end
            end
         end
         default: begin
            if (edge_seen) begin
               settle_in = 8'd0;
               prev_in   = 1'b0;
               if (cfg.settle_samples == 8'd0) begin
                  held_in = 8'd1;
                  usc_in  = 16'd0;
               end
            end else begin
               prev_in = level;
            end
         end
      endcase
   end

   // State registers advance once per accepted sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         prev_ff   <= 1'b1;
         settle_ff <= 8'd0;
         usc_ff    <= 16'd0;
         held_ff   <= 8'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         prev_ff   <= prev_in;
         settle_ff <= settle_in;
         usc_ff    <= usc_in;
         held_ff   <= held_in;
      end
   end

   // An event only comes from a unit check in the hold phase.
   `BPDC_ASSERT_SAME(a_event_in_hold, press_event != EV_NONE, phase_ff == PH_HOLD && unit_done && level, "press event outside a hold check")
   // Holding always has at least one unit counted.
   `BPDC_ASSERT_SAME(a_hold_units, phase_ff == PH_HOLD, held_ff != 8'd0, "hold phase with zero units")
   // A reported release returns to idle with the button seen released.
   `BPDC_ASSERT_NEXT(a_event_to_idle, step && press_event != EV_NONE, phase_ff == PH_IDLE && prev_ff, "no return to idle after event")

endmodule

`default_nettype wire

// ===== rtl/button_press_duration_classifier.sv =====
// ----------------------------------------------------------------------------
// button_press_duration_classifier
// Debounced short/long press detector for one active-low push button.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one button sample per word (bit 0, 0 = pressed).
//   The rsp channel returns one word per sample with the press event in
//   bits 1:0 (0 none, 1 short, 2 long). The csr channel writes the settle
//   length, hold unit length, short limit and timeout by register index.
//   A sample is latched in an input register and passes the state machine
//   into the output register, from which rsp returns it. One sample is
//   taken every clock cycle while the receiver keeps up; the state machine
//   updates once per sample.
//   Reset empties both registers, returns the detector to idle with the
//   button taken as released, and loads the default configuration.
//   When the receiver stalls, the output word holds, the input register
//   fills with one more sample, and req_tready then drops until rsp moves.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_duration_classifier
   import bpdc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [TDATA_W-1:0]     req_tdata,   // [0] button_level
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [TDATA_W-1:0]     rsp_tdata,   // [1:0] press_event
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

`include "button_press_duration_classifier_assert.svh"

   cfg_type            cfg;
   logic               in_valid_ff;
   logic               in_level_ff;
   logic               out_valid_ff;
   logic [EVENT_W-1:0] out_event_ff;
   logic [EVENT_W-1:0] press_event;
   logic               advance;
   logic               step;

   bpdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // The output register frees up when empty or when its word is taken.
   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   bpdc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .level       (in_level_ff),
      .cfg         (cfg),
      .press_event (press_event)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_level_ff <= req_tdata[0];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_event_ff <= press_event;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(TDATA_W-EVENT_W){1'b0}}, out_event_ff};

   // A processed sample always lands in the output register.
   `BPDC_ASSERT_NEXT(a_step_fills_out, step, out_valid_ff, "processed sample lost")
   // A held input sample is not dropped while the output is stalled.
   `BPDC_ASSERT_NEXT(a_in_held, in_valid_ff && !advance, in_valid_ff && $stable(in_level_ff), "input sample dropped during stall")
   // An empty input register always takes a new sample.
   `BPDC_ASSERT_SAME(a_in_ready, !in_valid_ff, req_tready, "empty input register not ready")

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button press classifier testbench
// Drives button samples into the classifier and checks every press event
// word against a cycle-free model of the debounce and hold timing. Covers
// directed presses, bounces, timeouts, zero and masked register values,
// the largest register values, random press sequences under several
// idling patterns, and a long output stall that backs up the input.
// ----------------------------------------------------------------------------

module testbench;
   import bpdc_pkg::*;

   // Register indexes that the block must ignore.
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_LOW = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_TOP = 8'hFF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [TDATA_W-1:0]     req_tdata = '0;     // [0] button_level
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [TDATA_W-1:0]     rsp_tdata;          // [1:0] press_event
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   button_press_duration_classifier i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Settings seen by the press model, and the settings the stimulus plans with.
   cfg_type active_cfg = '{RST_SETTLE_SAMPLES, RST_SAMPLES_PER_UNIT,
                           RST_SHORT_LIMIT_UNITS, RST_TIMEOUT_UNITS};
   cfg_type press_plan = '{RST_SETTLE_SAMPLES, RST_SAMPLES_PER_UNIT,
                           RST_SHORT_LIMIT_UNITS, RST_TIMEOUT_UNITS};

   // Detector state of the press model.
   phase_type   det_phase = PH_IDLE;
   logic        last_level = 1'b1;
   logic [7:0]  settle_run = '0;
   logic [15:0] unit_samples = '0;
   logic [7:0]  held_count = '0;

   logic [EVENT_W-1:0] expected_events[$];

   int errors = 0;
   int samples_offered = 0;
   int words_checked = 0;
   int short_seen = 0;
   int long_seen = 0;
   int csr_writes = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int long_stall_cycles = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("testbench: errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Press model
   // ------------------------------------------------------------------------

   // Hold timing starts at one unit and may end at once on a small timeout.
   function automatic void enter_hold();
      held_count = 8'd1;
      unit_samples = '0;
      if (held_count >= active_cfg.timeout_units) begin
         det_phase = PH_IDLE;
         last_level = 1'b0;
      end else begin
         det_phase = PH_HOLD;
      end
   endfunction

   // Advances the model by one sample and returns the event it reports.
   function automatic logic [EVENT_W-1:0] classify_sample(input logic level);
      logic [EVENT_W-1:0] event_code;
      event_code = EV_NONE;
      case (det_phase)
         PH_SETTLE: begin
            if (!level) begin
               if (settle_run != 8'hFF) settle_run++;
            end else begin
               settle_run = '0;
            end
            if (settle_run >= active_cfg.settle_samples) enter_hold();
         end
         PH_HOLD: begin
            if (unit_samples != 16'hFFFF) unit_samples++;
            // The level only matters when a hold unit completes.
            if (unit_samples >= active_cfg.samples_per_unit) begin
               unit_samples = '0;
               if (!level) begin
                  if (held_count != 8'hFF) held_count++;
                  if (held_count >= active_cfg.timeout_units) begin
                     det_phase = PH_IDLE;
                     last_level = 1'b0;
                  end
               end else begin
                  event_code = (held_count < active_cfg.short_limit_units) ?
                               EV_SHORT : EV_LONG;
                  det_phase = PH_IDLE;
                  last_level = 1'b1;
               end
            end
         end
         default: begin
            det_phase = PH_IDLE;
            if (!level && last_level) begin
               settle_run = '0;
               if (active_cfg.settle_samples == 0) begin
                  enter_hold();
               end else begin
                  det_phase = PH_SETTLE;
                  last_level = 1'b0;
               end
            end else begin
               last_level = level;
            end
         end
      endcase
      return event_code;
   endfunction

   // ------------------------------------------------------------------------
   // Monitor and checker
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset) begin
         // Accepted samples feed the model in order.
         if (req_tvalid && req_tready) begin
            expected_events.push_back(classify_sample(req_tdata[0]));
         end

         // Register writes update the model's settings.
         if (csr_valid && csr_ready) begin
            csr_writes++;
            case (csr_index)
               REG_SETTLE_SAMPLES:    active_cfg.settle_samples = csr_data[7:0];
               REG_SAMPLES_PER_UNIT:  active_cfg.samples_per_unit = csr_data;
               REG_SHORT_LIMIT_UNITS: active_cfg.short_limit_units = csr_data[7:0];
               REG_TIMEOUT_UNITS:     active_cfg.timeout_units = csr_data[7:0];
               default: ;
            endcase
         end

         // Each result word is compared with the oldest expected event.
         if (rsp_tvalid && rsp_tready) begin
            words_checked++;
            if (rsp_tdata[EVENT_W-1:0] == EV_SHORT) short_seen++;
            if (rsp_tdata[EVENT_W-1:0] == EV_LONG) long_seen++;
            if (expected_events.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result word %0d: event %0d",
                           words_checked, rsp_tdata[EVENT_W-1:0]);
            end else if (rsp_tdata[EVENT_W-1:0] !== expected_events[0]) begin
               errors++;
               if (errors <= 10)
                  $display("press event mismatch at word %0d: expected %0d, got %0d",
                           words_checked, expected_events[0], rsp_tdata[EVENT_W-1:0]);
               void'(expected_events.pop_front());
            end else begin
               void'(expected_events.pop_front());
            end
         end
      end
   end

   // Receiver: a long hold-off when asked, otherwise random stalls.
   always @(posedge clock) begin
      if (long_stall_cycles > 0) begin
         rsp_tready <= 1'b0;
         long_stall_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // Offers one button sample, after a random idle stretch, until accepted.
   task automatic send_sample(input logic level);
      int gaps;
      gaps = 0;
      while ($urandom_range(99) < sender_idle_pct) gaps++;
      if (gaps > 0) begin
         req_tvalid <= 1'b0;
         repeat (gaps) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(TDATA_W-1){1'b0}}, level};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_offered++;
   endtask

   // Sends a pattern of levels written as characters, first character first.
   task automatic send_levels(input string pattern);
      int i;
      for (i = 0; i < pattern.len(); i++) send_sample(pattern[i] == "1");
   endtask

   // Writes one register; the caller lowers csr_valid after its last write.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Stops offering samples and waits until every expected word has come.
   // It first lets the monitor queue the last accepted sample.
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Loads all four registers once the block has gone quiet.
   task automatic load_settings(input int settle, input int unit_len,
                                input int short_limit, input int timeout);
      wait_for_quiet();
      press_plan = '{settle[7:0], unit_len[15:0], short_limit[7:0], timeout[7:0]};
      csr_write(REG_SETTLE_SAMPLES, settle[15:0]);
      csr_write(REG_SAMPLES_PER_UNIT, unit_len[15:0]);
      csr_write(REG_SHORT_LIMIT_UNITS, short_limit[15:0]);
      csr_write(REG_TIMEOUT_UNITS, timeout[15:0]);
      csr_valid <= 1'b0;
   endtask

   // One well-formed press with random content: release, edge, optional
   // bounce, settling, then hold units ending in a release or a timeout.
   task automatic play_press();
      int unit_len;
      int max_checks;
      int checks;
      int k;
      bit timed_out;
      unit_len = (press_plan.samples_per_unit == 0) ? 1 : press_plan.samples_per_unit;
      max_checks = (press_plan.timeout_units > 11) ? 10 : press_plan.timeout_units - 1;
      repeat ($urandom_range(1, 3)) send_sample(1'b1);
      send_sample(1'b0);
      if (press_plan.settle_samples != 0 && $urandom_range(3) == 0) begin
         repeat ($urandom_range(0, press_plan.settle_samples - 1)) send_sample(1'b0);
         send_sample(1'b1);
      end
      repeat (press_plan.settle_samples) send_sample(1'b0);
      if (max_checks >= 1) begin
         timed_out = (press_plan.timeout_units <= 11) && ($urandom_range(4) == 0);
         checks = timed_out ? max_checks : $urandom_range(1, max_checks);
         for (k = 1; k <= checks; k++) begin
            // Samples between unit checks go unseen, so glitches are harmless.
            repeat (unit_len - 1) send_sample($urandom_range(3) == 0);
            send_sample(!timed_out && k == checks);
         end
      end
   endtask

   // Mostly presses, with bursts of random levels in between.
   task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                   input int n_items);
      int stop_at;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      stop_at = samples_offered + n_items;
      while (samples_offered < stop_at) begin
         if ($urandom_range(4) == 0)
            repeat ($urandom_range(2, 8)) send_sample($urandom_range(1));
         else
            play_press();
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset settings: an edge and a bounce during settling report nothing.
   task automatic test_reset_values();
      send_levels("101");
   endtask

   // Settling finishes from the earlier bounce, then a release on the
   // first check gives a short press.
   task automatic test_short_press();
      load_settings(2, 1, 2, 3);
      send_levels("001");
   endtask

   // A bounce restarts settling; two held units reach the short limit.
   task automatic test_bounce_and_long_press();
      send_levels("010001");
   endtask

   // Holding to the timeout ends silently; the held low gives no new edge.
   task automatic test_hold_timeout();
      send_levels("0000001");
   endtask

   // Zero values come from the low bytes of wider data; unknown indexes
   // are ignored. Zero timeouts end timing at once, zero limits make
   // every release long.
   task automatic test_zero_and_masked_settings();
      wait_for_quiet();
      press_plan = '{8'd0, 16'd0, 8'd0, 8'd1};
      csr_write(REG_SETTLE_SAMPLES, 16'hFF00);
      csr_write(REG_SAMPLES_PER_UNIT, 16'h0000);
      csr_write(REG_SHORT_LIMIT_UNITS, 16'h3400);
      csr_write(REG_TIMEOUT_UNITS, 16'h5601);
      csr_write(REG_UNUSED_LOW, 16'h0007);
      csr_write(REG_UNUSED_TOP, 16'hFFFF);
      csr_valid <= 1'b0;
      send_levels("100");
      wait_for_quiet();
      csr_write(REG_TIMEOUT_UNITS, 16'h0000);
      csr_valid <= 1'b0;
      send_levels("10");
      wait_for_quiet();
      csr_write(REG_TIMEOUT_UNITS, 16'h00C8);
      csr_valid <= 1'b0;
      send_levels("1001");
   endtask

   // Largest values: the edge enters a 65535-sample unit at once and the
   // samples inside it go unseen; a one-sample unit then ends the hold
   // with a short press under a 255-unit limit. A 255-sample settle is
   // started and bounced.
   task automatic test_largest_settings();
      load_settings(0, 65535, 255, 255);
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      send_levels("10");
      repeat (40) send_sample($urandom_range(1));
      load_settings(255, 1, 255, 255);
      send_levels("10100");
   endtask

   // Random presses under each idling pattern and several settings.
   task automatic test_random_presses();
      load_settings(RST_SETTLE_SAMPLES, 3, RST_SHORT_LIMIT_UNITS, RST_TIMEOUT_UNITS);
      run_random_phase(0, 0, 80);
      load_settings($urandom_range(1, 4), $urandom_range(1, 4),
                    $urandom_range(1, 6), $urandom_range(2, 8));
      run_random_phase(67, 0, 80);
      load_settings($urandom_range(1, 4), $urandom_range(1, 4),
                    $urandom_range(1, 6), $urandom_range(2, 8));
      run_random_phase(0, 67, 80);
      load_settings($urandom_range(1, 4), $urandom_range(1, 4),
                    $urandom_range(1, 6), $urandom_range(2, 8));
      run_random_phase(30, 30, 80);
      load_settings(1, 1, 1, 2);
      run_random_phase(30, 30, 40);
   endtask

   // The receiver holds off while presses keep coming, so the block fills
   // and stalls its input; then the sender waits for every result.
   task automatic test_output_backpressure();
      load_settings(2, 2, 3, 6);
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      long_stall_cycles = 150;
      play_press();
      play_press();
      wait_for_quiet();
      play_press();
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      int drain_cycles;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_short_press();
      test_bounce_and_long_press();
      test_hold_timeout();
      test_zero_and_masked_settings();
      test_largest_settings();
      test_random_presses();
      test_output_backpressure();

      // Let the last words come back, with a limit.
      req_tvalid <= 1'b0;
      drain_cycles = 0;
      while (expected_events.size() != 0 && drain_cycles < 20000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (8) @(posedge clock);
      if (expected_events.size() != 0) begin
         errors += expected_events.size();
         $display("%0d expected press events never arrived", expected_events.size());
      end

      $display("Run covered %0d button samples, %0d short and %0d long presses reported.",
               samples_offered, short_seen, long_seen);
      $display("%0d register writes across default, zero, largest and random settings.",
               csr_writes);
      if (errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("%0d errors", errors);
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
